@@ hdl/csfw_pkg.sv @@
package csfw_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int ID_BITS     = 8;
	localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
	localparam int FILL_BITS   = $clog2(QUEUE_DEPTH + 1);

	localparam int PID_W   = 8;
	localparam int COUNT_W = 8;
	localparam int WAIT_W  = 5;

	localparam logic [COUNT_W-1:0] COUNT_MAX  = 8'hFF;
	localparam logic [COUNT_W-1:0] COUNT_INIT = 8'd2;

	typedef enum logic {
		FN_WAIT   = 1'b0,
		FN_SIGNAL = 1'b1
	} func_t;

	typedef enum logic [2:0] {
		ST_GRANTED  = 3'd0,
		ST_QUEUED   = 3'd1,
		ST_RETURNED = 3'd2,
		ST_WOKEN    = 3'd3,
		ST_REFUSED  = 3'd4
	} status_t;

	typedef enum logic {
		CS_IDLE = 1'b0,
		CS_READ = 1'b1
	} ctl_state_t;

	typedef struct packed {
		func_t            func;
		logic [PID_W-1:0] process_id;
	} in_t;

	typedef struct packed {
		status_t            status;
		logic [PID_W-1:0]   woken_id;
		logic [COUNT_W-1:0] available;
		logic [WAIT_W-1:0]  waiting;
	} out_t;

	typedef struct packed {
		logic                we;
		logic [PTR_BITS-1:0] waddr;
		logic [ID_BITS-1:0]  wdata;
		logic                re;
		logic [PTR_BITS-1:0] raddr;
	} ram_req_t;

	function automatic logic [PTR_BITS-1:0] ptr_next(input logic [PTR_BITS-1:0] p);
		return (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

endpackage

@@ hdl/csfw_wait_ram.sv @@
module csfw_wait_ram
	import csfw_pkg::*;
(
	input  logic               clk,
	input  ram_req_t           req,
	output logic [ID_BITS-1:0] rdata
);

	logic [ID_BITS-1:0] mem [QUEUE_DEPTH];
	logic [ID_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/csfw_ctrl.sv @@
module csfw_ctrl
	import csfw_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  in_t                in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output out_t               out_data,
	input  logic               cfg_valid,
	input  logic [COUNT_W-1:0] cfg_data,
	output ram_req_t           ram_req,
	input  logic [ID_BITS-1:0] ram_rdata
);

	ctl_state_t          state_q, state_d;
	logic [COUNT_W-1:0]  count_q, count_d;
	logic [PTR_BITS-1:0] head_q, head_d;
	logic [PTR_BITS-1:0] tail_q, tail_d;
	logic [FILL_BITS-1:0] fill_q, fill_d;
	logic                out_valid_q;
	out_t                out_q;
	status_t             status_d;
	logic                take;
	logic                wake;

	always_comb begin
		in_ready = (state_q == CS_IDLE) && (!out_valid_q || out_ready);
		take     = in_valid && in_ready;
		count_d  = count_q;
		head_d   = head_q;
		tail_d   = tail_q;
		fill_d   = fill_q;
		status_d = ST_REFUSED;
		wake     = 1'b0;
		ram_req  = '0;
		ram_req.waddr = tail_q;
		ram_req.wdata = ID_BITS'(in_data.process_id);
		ram_req.raddr = head_q;

		case (in_data.func)
			FN_WAIT: begin
				if (count_q != '0) begin
					count_d  = count_q - 1'b1;
					status_d = ST_GRANTED;
				end else if (fill_q != FILL_BITS'(QUEUE_DEPTH)) begin
					ram_req.we = take;
					tail_d     = ptr_next(tail_q);
					fill_d     = fill_q + 1'b1;
					status_d   = ST_QUEUED;
				end
			end
			FN_SIGNAL: begin
				if (fill_q != '0) begin
					ram_req.re = take;
					wake       = 1'b1;
					head_d     = ptr_next(head_q);
					fill_d     = fill_q - 1'b1;
					status_d   = ST_WOKEN;
				end else if (count_q != COUNT_MAX) begin
					count_d  = count_q + 1'b1;
					status_d = ST_RETURNED;
				end
			end
			default: begin
				status_d = ST_REFUSED;
			end
		endcase

		state_d = state_q;
		case (state_q)
			CS_IDLE: begin
				if (take && wake) begin
					state_d = CS_READ;
				end
			end
			CS_READ: begin
				state_d = CS_IDLE;
			end
			default: begin
				state_d = CS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CS_IDLE;
			count_q     <= COUNT_INIT;
			head_q      <= '0;
			tail_q      <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// register write reloads the count; queue is left alone
			if (cfg_valid) begin
				count_q <= cfg_data;
			end else if (take) begin
				count_q <= count_d;
			end
			if (take) begin
				head_q <= head_d;
				tail_q <= tail_d;
				fill_q <= fill_d;
			end
			if ((take && !wake) || state_q == CS_READ) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q.status    <= status_d;
			out_q.woken_id  <= '0;
			out_q.available <= count_d;
			out_q.waiting   <= WAIT_W'(fill_d);
		end else if (state_q == CS_READ) begin
			out_q.woken_id <= PID_W'(ram_rdata);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ hdl/counting_semaphore_fifo_wait.sv @@
// Counting semaphore with a FIFO queue of blocked requesters.
// Request channel (in_valid/in_ready/in_data): func selects wait or signal;
// process_id names the requester of a wait. Each request yields exactly one
// result on out_valid/out_ready/out_data: status, woken ID, count and queue fill
// after the operation.
// cfg_valid/cfg_data loads the unit count; cfg_ready is always high. Write it
// only while no request is in flight; the queue is not touched.
// Timing: the result is registered in the cycle after acceptance. A signal that
// wakes a waiter reads the queue memory first and loads the ID from CS_READ.
// Throughput: one request per cycle unless the output stalls, except a waking
// signal, which holds the request channel in CS_READ for the single read port.
// Reset: count is 2, queue empty, output empty; no memory clearing pass.
// Output stall: the result register holds; a new request is taken in the same
// cycle the pending result is taken, otherwise in_ready stays low.
module counting_semaphore_fifo_wait
	import csfw_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  in_t                in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output out_t               out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [COUNT_W-1:0] cfg_data
);

	ram_req_t           ram_req;
	logic [ID_BITS-1:0] ram_rdata;

	assign cfg_ready = 1'b1;

	csfw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	csfw_wait_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	// a waking read blocks the next request until its data lands
	a_read_interlock: assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.re |=> !in_ready)
		else $error("request accepted while wait memory read pending");

	a_read_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.re |-> ##2 out_valid)
		else $error("woken result not delivered after memory read");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_req.we && ram_req.re))
		else $error("wait memory written and read in one cycle");

	a_queued_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status == ST_QUEUED) |-> out_data.waiting != '0)
		else $error("queued result reports an empty queue");

endmodule
